### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg - shared types and constants for the double-ended queue
// Request and response payload structs, operation and status codes, and the
// default store depth.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int WORD_W        = 32;
	localparam int FILL_W        = 7;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_REAR  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_REAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [WORD_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [WORD_W-1:0]  front_value;
		logic signed [WORD_W-1:0]  rear_value;
		logic                      is_empty;
		logic        [FILL_W-1:0]  fill_count;
	} rsp_t;

endpackage

### rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core - bounded deque of signed 32-bit words
// Circular store addressed by a head index and an element count.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless out_ready stalls the output (push
// front, push rear, pop front, pop rear) and returns one response per
// request: status, front and rear words after the operation (zero when
// empty), an empty flag and the fill count, via stage 1 and the output
// register. The rate is set by the single write port and registered read
// of the word store, which reads the new front and rear entries in the
// same cycle as the write, forwarding the pushed word on address match.
// Pops on an empty deque report underflow and pushes on a full one report
// overflow; neither changes the contents. No clearing pass after reset.
module double_ended_queue_core #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  deq_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output deq_pkg::rsp_t out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 2;

	localparam logic [SW-1:0] DEPTH_W   = SW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic                          in_acc;
	logic                          s1_adv;
	logic [AW-1:0]                 head_n;
	logic [CW-1:0]                 count_n;
	deq_pkg::status_t              status_n;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [AW-1:0]                 rear_addr;
	logic [SW-1:0]                 wr_sum;
	logic [SW-1:0]                 rear_sum;
	logic [deq_pkg::WORD_W-1:0]    rd_front;
	logic [deq_pkg::WORD_W-1:0]    rd_rear;

	logic                          valid_s1;
	deq_pkg::status_t              status_s1;
	logic [CW-1:0]                 count_s1;
	logic                          fwd_front_s1;
	logic                          fwd_rear_s1;
	logic [deq_pkg::WORD_W-1:0]    word_s1;

	logic                          out_valid_q;
	deq_pkg::rsp_t                 out_data_q;
	deq_pkg::rsp_t                 rsp_n;

	// handshake: stage 1 moves on when the output register is free
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_acc   = in_valid && in_ready;

	// decode the request and update head, count and write address
	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		status_n = deq_pkg::ST_OK;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		wr_sum   = SW'(head_q) + SW'(count_q);
		if (wr_sum >= DEPTH_W) begin
			wr_sum = wr_sum - DEPTH_W;
		end
		case (in_data.mode)
			deq_pkg::MODE_PUSH_FRONT: begin
				if (count_q == FULL_CNT) begin
					status_n = deq_pkg::ST_OVERFLOW;
				end else begin
					head_n  = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
					count_n = count_q + CW'(1);
					wr_en   = 1'b1;
					wr_addr = head_n;
				end
			end
			deq_pkg::MODE_PUSH_REAR: begin
				if (count_q == FULL_CNT) begin
					status_n = deq_pkg::ST_OVERFLOW;
				end else begin
					count_n = count_q + CW'(1);
					wr_en   = 1'b1;
					wr_addr = wr_sum[AW-1:0];
				end
			end
			deq_pkg::MODE_POP_FRONT: begin
				if (count_q == '0) begin
					status_n = deq_pkg::ST_UNDERFLOW;
				end else begin
					head_n  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
					count_n = count_q - CW'(1);
				end
			end
			deq_pkg::MODE_POP_REAR: begin
				if (count_q == '0) begin
					status_n = deq_pkg::ST_UNDERFLOW;
				end else begin
					count_n = count_q - CW'(1);
				end
			end
			default: begin
				status_n = deq_pkg::ST_OK;
			end
		endcase
	end

	// locate the rear entry after the operation
	always_comb begin
		rear_sum = SW'(head_n) + SW'(count_n) - SW'(1);
		if (rear_sum >= DEPTH_W) begin
			rear_sum = rear_sum - DEPTH_W;
		end
		rear_addr = rear_sum[AW-1:0];
	end

	// word store: write pushed word, read new front and rear
	deq_ram #(
		.WIDTH (deq_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk       (clk),
		.wr_en     (in_acc && wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (in_data.value),
		.rd_en     (in_acc),
		.rd_addr_a (head_n),
		.rd_addr_b (rear_addr),
		.rd_data_a (rd_front),
		.rd_data_b (rd_rear)
	);

	// pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (in_acc) begin
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload: hold status, count and forwarding marks
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1    <= status_n;
			count_s1     <= count_n;
			fwd_front_s1 <= wr_en && (wr_addr == head_n);
			fwd_rear_s1  <= wr_en && (wr_addr == rear_addr);
			word_s1      <= in_data.value;
		end
	end

	// build the response from store data, forwarding the pushed word
	always_comb begin
		rsp_n.status      = status_s1;
		rsp_n.is_empty    = (count_s1 == '0);
		rsp_n.fill_count  = deq_pkg::FILL_W'(count_s1);
		rsp_n.front_value = fwd_front_s1 ? word_s1 : rd_front;
		rsp_n.rear_value  = fwd_rear_s1  ? word_s1 : rd_rear;
		if (count_s1 == '0) begin
			rsp_n.front_value = '0;
			rsp_n.rear_value  = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= rsp_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram - generic synchronous RAM
// One write port and two read ports; read data is registered and held
// while read enable is low.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule
